// ===== hdl/dmaseq_pkg.sv =====
// ----------------------------------------------------------------------------
// dmaseq_pkg
// Shared types and constants for the four-channel DMA audio sequencer.
// ----------------------------------------------------------------------------
package dmaseq_pkg;

   localparam int NUM_CH          = 4;
   localparam int VALUE_W         = 21;
   localparam int SAMPLE_W        = 16;
   localparam int FETCH_ADDR_W    = 20;
   localparam int MAX_ADDR_BITS   = 24;
   localparam int DEF_ADDR_BITS   = 21;
   localparam int DEF_MIN_PERIOD  = 124;
   localparam int REQ_DATA_W      = 32;
   localparam int RSP_DATA_W      = 152;

   localparam int SETCLR_BIT      = 15;
   localparam int DMA_MASTER_BIT  = 9;
   localparam int MOD_PER_OFFSET  = 4;

   typedef enum logic {
      KIND_TICK  = 1'b0,
      KIND_WRITE = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      TGT_DMACON   = 3'd0,
      TGT_ADKCON   = 3'd1,
      TGT_LOCATION = 3'd2,
      TGT_LENGTH   = 3'd3,
      TGT_PERIOD   = 3'd4,
      TGT_VOLUME   = 3'd5,
      TGT_DATA     = 3'd6,
      TGT_NONE     = 3'd7
   } target_type;

   // modulation handed from one channel to the next
   typedef struct packed {
      logic        per_valid;
      logic        vol_valid;
      logic [15:0] mod_data;
   } link_type;

   typedef struct packed {
      kind_type                                kind;
      target_type                              target;
      logic [1:0]                              channel;
      logic [VALUE_W-1:0]                      value;
      link_type                                link;
      logic [NUM_CH-1:0][SAMPLE_W-1:0]         sample;
      logic [NUM_CH-1:0]                       fetch_mask;
      logic [NUM_CH-1:0][FETCH_ADDR_W-1:0]     fetch_addr;
      logic [NUM_CH-1:0]                       irq;
   } beat_type;

   function automatic logic set_clear_bit(logic old_bit, logic set, logic data_bit);
      return set ? (old_bit | data_bit) : (old_bit & ~data_bit);
   endfunction

endpackage

// ===== hdl/dmaseq_cell.sv =====
// ----------------------------------------------------------------------------
// dmaseq_cell
// One audio channel: register file, period counter, DMA pointer and sample
// multiply. Takes a beat from the previous cell and registers it onward.
// ----------------------------------------------------------------------------
module dmaseq_cell #(
   parameter int CH         = 0,
   parameter int ADDR_BITS  = dmaseq_pkg::DEF_ADDR_BITS,
   parameter int MIN_PERIOD = dmaseq_pkg::DEF_MIN_PERIOD
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  dmaseq_pkg::beat_type in_beat,
   output logic                 out_valid,
   output dmaseq_pkg::beat_type out_beat
);
   import dmaseq_pkg::*;

   localparam logic [15:0] MinPeriod = 16'(MIN_PERIOD);

   logic                  dma_master_ff, dma_master_in;
   logic                  dma_bit_ff, dma_bit_in;
   logic                  enabled_ff, enabled_in;
   logic                  mod_vol_ff, mod_vol_in;
   logic                  mod_per_ff, mod_per_in;
   logic [ADDR_BITS-1:0]  start_loc_ff, start_loc_in;
   logic [15:0]           start_len_ff, start_len_in;
   logic [15:0]           period_ff, period_in;
   logic [6:0]            volume_ff, volume_in;
   logic [ADDR_BITS-1:0]  loc_ff, loc_in;
   logic [15:0]           len_ff, len_in;
   logic [15:0]           count_ff, count_in;
   logic [15:0]           data_ff, data_in;
   logic                  valid_ff;
   beat_type              beat_ff, beat_in;

   logic [MAX_ADDR_BITS-1:0] value_ext;
   logic [MAX_ADDR_BITS-1:0] loc_ext;
   logic [ADDR_BITS-1:0]     loc_inc;
   logic [6:0]               vol_sel;
   logic [6:0]               vol_norm;
   logic [8:0]               gain;
   logic [7:0]               byte_sel;
   logic signed [17:0]       product;
   logic [15:0]              per_sel;
   logic [15:0]              per_reload;
   logic [15:0]              len_dec;
   logic                     set_bit;

   assign value_ext  = MAX_ADDR_BITS'(in_beat.value);
   assign loc_inc    = loc_ff + 1'b1;
   assign loc_ext    = MAX_ADDR_BITS'(loc_inc);
   assign vol_sel    = in_beat.link.vol_valid ? in_beat.link.mod_data[6:0] : volume_ff;
   assign vol_norm   = vol_sel[6] ? 7'd64 : {1'b0, vol_sel[5:0]};
   assign gain       = {vol_norm, 2'b00};
   assign byte_sel   = loc_ff[0] ? data_ff[7:0] : data_ff[15:8];
   assign product    = $signed(byte_sel) * $signed({1'b0, gain});
   assign per_sel    = in_beat.link.per_valid ? in_beat.link.mod_data : period_ff;
   assign per_reload = (per_sel < MinPeriod) ? MinPeriod : per_sel;
   assign len_dec    = (len_ff != 16'd0) ? len_ff - 16'd1 : 16'd0;
   assign set_bit    = in_beat.value[SETCLR_BIT];

   always_comb begin
      dma_master_in = dma_master_ff;
      dma_bit_in    = dma_bit_ff;
      enabled_in    = enabled_ff;
      mod_vol_in    = mod_vol_ff;
      mod_per_in    = mod_per_ff;
      start_loc_in  = start_loc_ff;
      start_len_in  = start_len_ff;
      period_in     = period_ff;
      volume_in     = volume_ff;
      loc_in        = loc_ff;
      len_in        = len_ff;
      count_in      = count_ff;
      data_in       = data_ff;
      beat_in       = in_beat;
      if (in_valid) begin
         if (in_beat.kind == KIND_WRITE) begin
            unique case (in_beat.target)
               TGT_DMACON: begin
                  dma_master_in = set_clear_bit(dma_master_ff, set_bit,
                                                in_beat.value[DMA_MASTER_BIT]);
                  dma_bit_in    = set_clear_bit(dma_bit_ff, set_bit, in_beat.value[CH]);
                  enabled_in    = dma_master_in & dma_bit_in;
                  if (enabled_in && !enabled_ff) begin
                     loc_in           = start_loc_ff;
                     len_in           = start_len_ff;
                     beat_in.irq[CH]  = 1'b1;
                  end
               end
               TGT_ADKCON: begin
                  mod_vol_in = set_clear_bit(mod_vol_ff, set_bit, in_beat.value[CH]);
                  mod_per_in = set_clear_bit(mod_per_ff, set_bit,
                                             in_beat.value[MOD_PER_OFFSET + CH]);
               end
               TGT_LOCATION: if (in_beat.channel == 2'(CH)) start_loc_in = value_ext[ADDR_BITS-1:0];
               TGT_LENGTH:   if (in_beat.channel == 2'(CH)) start_len_in = in_beat.value[15:0];
               TGT_PERIOD:   if (in_beat.channel == 2'(CH)) period_in    = in_beat.value[15:0];
               TGT_VOLUME:   if (in_beat.channel == 2'(CH)) volume_in    = in_beat.value[6:0];
               TGT_DATA:     if (in_beat.channel == 2'(CH)) data_in      = in_beat.value[15:0];
               default: ;
            endcase
         end else begin
            beat_in.link.mod_data = data_ff;
            if (mod_per_ff) begin
               beat_in.link.per_valid = 1'b1;
               beat_in.link.vol_valid = 1'b0;
               beat_in.sample[CH]     = '0;
            end else if (mod_vol_ff) begin
               beat_in.link.per_valid = 1'b0;
               beat_in.link.vol_valid = 1'b1;
               beat_in.sample[CH]     = '0;
            end else begin
               beat_in.link.per_valid = 1'b0;
               beat_in.link.vol_valid = 1'b0;
               beat_in.sample[CH]     = product[SAMPLE_W-1:0];
            end
            if (count_ff <= 16'd1) begin
               count_in = per_reload;
               if (enabled_ff) begin
                  loc_in = loc_inc;
                  if (!loc_inc[0]) begin
                     beat_in.fetch_mask[CH] = 1'b1;
                     beat_in.fetch_addr[CH] = loc_ext[FETCH_ADDR_W:1];
                     len_in                 = len_dec;
                     if (len_dec == 16'd0) begin
                        loc_in          = start_loc_ff;
                        len_in          = start_len_ff;
                        beat_in.irq[CH] = 1'b1;
                     end
                  end
               end
            end else begin
               count_in = count_ff - 16'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         dma_master_ff <= 1'b0;
         dma_bit_ff    <= 1'b0;
         enabled_ff    <= 1'b0;
         mod_vol_ff    <= 1'b0;
         mod_per_ff    <= 1'b0;
         start_loc_ff  <= '0;
         start_len_ff  <= '0;
         period_ff     <= '0;
         volume_ff     <= '0;
         loc_ff        <= '0;
         len_ff        <= '0;
         count_ff      <= '0;
         data_ff       <= '0;
      end else if (advance) begin
         valid_ff      <= in_valid;
         dma_master_ff <= dma_master_in;
         dma_bit_ff    <= dma_bit_in;
         enabled_ff    <= enabled_in;
         mod_vol_ff    <= mod_vol_in;
         mod_per_ff    <= mod_per_in;
         start_loc_ff  <= start_loc_in;
         start_len_ff  <= start_len_in;
         period_ff     <= period_in;
         volume_ff     <= volume_in;
         loc_ff        <= loc_in;
         len_ff        <= len_in;
         count_ff      <= count_in;
         data_ff       <= data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         beat_ff <= beat_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

endmodule

// ===== hdl/four_channel_dma_audio_sequencer.sv =====
// ----------------------------------------------------------------------------
// four_channel_dma_audio_sequencer
// Four-channel DMA sample playback engine with period/volume modulation.
// ----------------------------------------------------------------------------
// Each request beat is a tick (tuser = 0) or a register write (tuser = 1)
// and yields exactly one response beat. The beat walks a row of four channel
// cells, one cell per cycle, each cell updating its channel and filling in
// its sample, fetch and interrupt fields and passing modulation data on to
// the next channel. A new beat is taken every cycle while the response side
// keeps up, and the whole row holds when a response beat waits.
module four_channel_dma_audio_sequencer #(
   parameter int ADDR_BITS  = dmaseq_pkg::DEF_ADDR_BITS,
   parameter int MIN_PERIOD = dmaseq_pkg::DEF_MIN_PERIOD
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // target[2:0], channel[4:3], value[25:5], zero fill
   input  logic [dmaseq_pkg::REQ_DATA_W-1:0]  req_tdata,
   // kind[0]
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // sample_ch0..3[63:0], fetch_mask[67:64], fetch_addr0..3[147:68], irq_mask[151:148]
   output logic [dmaseq_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import dmaseq_pkg::*;

   logic     advance;
   logic     valid_chain [NUM_CH+1];
   beat_type beat_chain  [NUM_CH+1];
   beat_type req_beat;

   assign advance    = !valid_chain[NUM_CH] || rsp_tready;
   assign req_tready = advance;

   always_comb begin
      req_beat          = '0;
      req_beat.kind     = kind_type'(req_tuser);
      req_beat.target   = target_type'(req_tdata[2:0]);
      req_beat.channel  = req_tdata[4:3];
      req_beat.value    = req_tdata[25:5];
   end
   assign beat_chain[0]  = req_beat;
   assign valid_chain[0] = req_tvalid;

   for (genvar c = 0; c < NUM_CH; c++) begin : g_cell
      dmaseq_cell #(
         .CH         (c),
         .ADDR_BITS  (ADDR_BITS),
         .MIN_PERIOD (MIN_PERIOD)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (valid_chain[c]),
         .in_beat   (beat_chain[c]),
         .out_valid (valid_chain[c+1]),
         .out_beat  (beat_chain[c+1])
      );
   end

   assign rsp_tvalid = valid_chain[NUM_CH];
   assign rsp_tdata  = {beat_chain[NUM_CH].irq,
                        beat_chain[NUM_CH].fetch_addr,
                        beat_chain[NUM_CH].fetch_mask,
                        beat_chain[NUM_CH].sample};

   a_ready_follows_output: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("request ready does not track response backpressure");

   a_write_no_samples: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && beat_chain[NUM_CH].kind == KIND_WRITE |->
         rsp_tdata[147:0] == '0)
      else $error("register write beat carries sample or fetch data");

   a_tick_irq_needs_fetch: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && beat_chain[NUM_CH].kind == KIND_TICK |->
         (rsp_tdata[151:148] & ~rsp_tdata[67:64]) == 4'b0000)
      else $error("tick interrupt without a fetch on that channel");

endmodule
